### rtl/core/dmrd_pkg.sv
// ----------------------------------------------------------------------------
// dmrd_pkg
// Shared types, sizes and helpers for the rank-order depth mip downsampler.
// ----------------------------------------------------------------------------
package dmrd_pkg;

	localparam int unsigned MAX_SRC_W = 4096;
	localparam int unsigned MAX_SRC_H = 4096;

	localparam int unsigned DEPTH_W = 16;
	localparam int unsigned CFG_W   = 12;
	localparam int unsigned COL_W   = $clog2(MAX_SRC_W);
	localparam int unsigned ROW_W   = $clog2(MAX_SRC_H);
	localparam int unsigned HALF_W  = MAX_SRC_W / 2;
	localparam int unsigned HALF_H  = MAX_SRC_H / 2;
	localparam int unsigned LB_ADDR_W = COL_W - 1;

	localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = CFG_W'(2048);
	localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = CFG_W'(2048);

	typedef logic [DEPTH_W-1:0] depth_t;

	typedef enum logic [0:0] {
		CFG_OUT_WIDTH  = 1'b0,
		CFG_OUT_HEIGHT = 1'b1
	} cfg_idx_t;

	// Last source index for an output dimension: 2*clamp(v, 1, half) - 1.
	function automatic int unsigned last_index(logic [CFG_W-1:0] v, int unsigned half);
		int unsigned t;
		t = 32'(v);
		if (t == 0) begin
			t = 1;
		end else if (t > half) begin
			t = half;
		end
		return 2 * t - 1;
	endfunction

endpackage

### rtl/core/dmrd_ram.sv
// ----------------------------------------------------------------------------
// dmrd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dmrd_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/dmrd_rank4.sv
// ----------------------------------------------------------------------------
// dmrd_rank4
// Third smallest (upper median) of four samples, five compare-exchange network.
// ----------------------------------------------------------------------------
module dmrd_rank4 (
	input  dmrd_pkg::depth_t a,
	input  dmrd_pkg::depth_t b,
	input  dmrd_pkg::depth_t c,
	input  dmrd_pkg::depth_t d,
	output dmrd_pkg::depth_t third
);

	dmrd_pkg::depth_t a1, b1, c1, d1, b2, c2;

	always_comb begin
		// layer 1: (a,b) and (c,d)
		a1 = (a > b) ? b : a;
		b1 = (a > b) ? a : b;
		c1 = (c > d) ? d : c;
		d1 = (c > d) ? c : d;
		// layer 2: only the middle pair is kept, min and max drop out
		c2 = (a1 > c1) ? a1 : c1;
		b2 = (b1 > d1) ? d1 : b1;
		// middle pair, upper one wins
		third = (b2 > c2) ? b2 : c2;
	end

endmodule

### rtl/core/depth_mip_rank_downsample.sv
// ----------------------------------------------------------------------------
// depth_mip_rank_downsample
// One level of a 2x2 rank-order (upper median) depth mip chain.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* takes source depth samples in raster order, one 16-bit word per
//    handshake. The source frame is 2*out_width by 2*out_height samples.
//  - m_* gives one word per 2x2 block: tdata = upper median, tlast = last
//    pixel of an output row, tuser = last pixel of the frame.
//  - cfg_we/cfg_index/cfg_data write out_width (index 0) and out_height
//    (index 1); write only between frames while the block is drained.
//    Zero reads as 1, values above half the max source size saturate.
//  - Throughput: one source word per clock while s_tready is high. The word
//    that closes a block is registered in the line buffer read register and
//    stage 1 first, then moves on to the output register.
//  - Even source rows go into a line buffer, split into even-column and
//    odd-column RAMs so both upper samples of a pair come out in one read.
//  - Reset clears counters, held left sample and valid flags; the line
//    buffer holds garbage until the first even row writes it.
//  - When m_tready is low the output word holds; s_tready drops only once
//    a finished result is parked in the read stage behind it.
// ----------------------------------------------------------------------------
module depth_mip_rank_downsample (
	input  logic        clk,
	input  logic        arst_n,
	// source samples
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] depth_in
	// mip results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] depth_out
	output logic        m_tlast,   // row_end
	output logic [0:0]  m_tuser,   // [0] frame_end
	// configuration
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int unsigned COL_W = dmrd_pkg::COL_W;
	localparam int unsigned ROW_W = dmrd_pkg::ROW_W;
	localparam int unsigned AW    = dmrd_pkg::LB_ADDR_W;

	// ---------------- configuration registers ----------------
	logic [dmrd_pkg::CFG_W-1:0] out_width_q, out_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q  <= dmrd_pkg::OUT_WIDTH_RST;
			out_height_q <= dmrd_pkg::OUT_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (dmrd_pkg::cfg_idx_t'(cfg_index))
				dmrd_pkg::CFG_OUT_WIDTH:  out_width_q  <= cfg_data;
				dmrd_pkg::CFG_OUT_HEIGHT: out_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// last source column/row after clamping
	logic [COL_W-1:0] last_col;
	logic [ROW_W-1:0] last_row;

	assign last_col = COL_W'(dmrd_pkg::last_index(out_width_q, dmrd_pkg::HALF_W));
	assign last_row = ROW_W'(dmrd_pkg::last_index(out_height_q, dmrd_pkg::HALF_H));

	// ---------------- input side / position tracking ----------------
	logic             accept;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             at_last_col, at_last_row;
	logic             odd_row, odd_col;
	logic             closes_block;
	dmrd_pkg::depth_t left_q;

	assign accept       = s_tvalid && s_tready;
	assign at_last_col  = (col_q >= last_col);
	assign at_last_row  = (row_q >= last_row);
	assign odd_row      = row_q[0];
	assign odd_col      = col_q[0];
	assign closes_block = odd_row && odd_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= at_last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
			// hold left sample of the pair on odd rows
			if (odd_row && !odd_col) begin
				left_q <= s_tdata;
			end
		end
	end

	// ---------------- line buffer (even source row) ----------------
	dmrd_pkg::depth_t ul_rd, ur_rd;
	logic             lb_we_even, lb_we_odd;
	logic [AW-1:0]    lb_addr;

	// pair index: both columns of a pair share one address
	assign lb_addr    = col_q[COL_W-1:1];
	assign lb_we_even = accept && !odd_row && !odd_col;
	assign lb_we_odd  = accept && !odd_row && odd_col;

	dmrd_ram #(
		.WIDTH(dmrd_pkg::DEPTH_W),
		.DEPTH(dmrd_pkg::HALF_W)
	) u_lb_even (
		.clk   (clk),
		.we    (lb_we_even),
		.waddr (lb_addr),
		.wdata (s_tdata),
		.re    (accept),
		.raddr (lb_addr),
		.rdata (ul_rd)
	);

	dmrd_ram #(
		.WIDTH(dmrd_pkg::DEPTH_W),
		.DEPTH(dmrd_pkg::HALF_W)
	) u_lb_odd (
		.clk   (clk),
		.we    (lb_we_odd),
		.waddr (lb_addr),
		.wdata (s_tdata),
		.re    (accept),
		.raddr (lb_addr),
		.rdata (ur_rd)
	);

	// ---------------- stage 1: aligned with line buffer read ----------------
	logic             res_s1;
	dmrd_pkg::depth_t x_s1, left_s1;
	logic             row_end_s1, frame_end_s1;
	logic             out_free;

	assign out_free = !m_tvalid || m_tready;
	// s1 only blocks when it holds a result that cannot move on
	assign s_tready = !res_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= 1'b0;
		end else if (s_tready) begin
			res_s1 <= accept && closes_block;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1         <= s_tdata;
			left_s1      <= left_q;
			row_end_s1   <= at_last_col;
			frame_end_s1 <= at_last_col && at_last_row;
		end
	end

	// ---------------- rank select and output register ----------------
	dmrd_pkg::depth_t median;

	dmrd_rank4 u_rank4 (
		.a     (ul_rd),
		.b     (ur_rd),
		.c     (left_s1),
		.d     (x_s1),
		.third (median)
	);

	logic             out_valid_q;
	dmrd_pkg::depth_t out_depth_q;
	logic             out_row_end_q, out_frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_s1) begin
			out_depth_q     <= median;
			out_row_end_q   <= row_end_s1;
			out_frame_end_q <= frame_end_s1;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_depth_q;
	assign m_tlast    = out_row_end_q;
	assign m_tuser[0] = out_frame_end_q;

endmodule

### rtl/core/dmrd_checker.sv
// ----------------------------------------------------------------------------
// dmrd_checker
// Port-level checks for the depth mip downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module dmrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast,
	input logic [0:0]  m_tuser
);

	// frame end is always also a row end
	a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("frame end without row end");

	// input never stalls while the output side can take a word
	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with free output");

	// stalled word stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("output word changed under stall");

endmodule

bind depth_mip_rank_downsample dmrd_checker u_dmrd_checker (.*);
